>>> rtl/k_bit_value_packer_unit_macros.svh
// Assertion macros shared by the K-bit packer RTL.
// No dependencies; included by modules that carry assertions.
`ifndef K_BIT_VALUE_PACKER_UNIT_MACROS_SVH
`define K_BIT_VALUE_PACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define KBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define KBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/kbp_pkg.sv
// Shared types and constants for the K-bit value packer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package kbp_pkg;

  localparam int unsigned NUM_LANES  = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;

  typedef logic [7:0]            octet_t;
  typedef octet_t [NUM_LANES-1:0] octet_vec_t;
  typedef logic [3:0]            kwidth_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_VALUE_WIDTH = 1'b0;
  localparam cfg_idx_t REG_DIRECTION   = 1'b1;

  localparam logic DIR_PACK   = 1'b0;
  localparam logic DIR_UNPACK = 1'b1;

  localparam kwidth_t K_MIN = 4'd1;
  localparam kwidth_t K_MAX = 4'd8;

endpackage

`default_nettype wire

>>> rtl/kbp_in_stage.sv
// Input register of the K-bit packer: captures one item per accepted handshake.
// Depends on kbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kbp_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire kbp_pkg::octet_vec_t in_data,
  input  wire logic               down_ready,
  output logic                    s1_valid,
  output kbp_pkg::octet_vec_t     s1_data
);
  import kbp_pkg::*;

  logic       valid_r, valid_nxt;
  octet_vec_t data_r;
  logic       load;

  assign in_stall = valid_r && !down_ready;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (down_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;

endmodule

`default_nettype wire

>>> rtl/kbp_xform.sv
// Pack and unpack bit placement for K from 1 to 8.
// Depends on kbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kbp_xform (
  input  wire kbp_pkg::octet_vec_t src,
  input  wire kbp_pkg::kwidth_t    k,
  input  wire logic                dir,
  output kbp_pkg::octet_vec_t      dst,
  output kbp_pkg::kwidth_t         count
);
  import kbp_pkg::*;

  octet_vec_t packed_y;
  octet_vec_t unpacked_v;

  always_comb begin
    packed_y = '0;
    case (k)
      4'd1: begin
        for (int i = 0; i < 8; i++) begin
          packed_y[0][i] = src[i][0];
        end
      end
      4'd2: begin
        for (int g = 0; g < 2; g++) begin
          packed_y[g] = {src[4*g+3][1:0], src[4*g+2][1:0], src[4*g+1][1:0], src[4*g][1:0]};
        end
      end
      4'd3: begin
        packed_y[0] = {src[2][1:0], src[1][2:0], src[0][2:0]};
        packed_y[1] = {src[5][2], src[2][2], src[4][2:0], src[3][2:0]};
        packed_y[2] = {src[5][1:0], src[7][2:0], src[6][2:0]};
      end
      4'd4: begin
        for (int g = 0; g < 4; g++) begin
          packed_y[g] = {src[2*g+1][3:0], src[2*g][3:0]};
        end
      end
      4'd5: begin
        for (int g = 0; g < 4; g++) begin
          packed_y[g] = {src[2*g+1][4:2], src[2*g][4:0]};
        end
        packed_y[4] = {src[7][1:0], src[5][1:0], src[3][1:0], src[1][1:0]};
      end
      4'd6: begin
        for (int g = 0; g < 2; g++) begin
          packed_y[3*g]   = {src[4*g+1][5:4], src[4*g][5:0]};
          packed_y[3*g+1] = {src[4*g+2][3:0], src[4*g+1][3:0]};
          packed_y[3*g+2] = {src[4*g+2][5:4], src[4*g+3][5:0]};
        end
      end
      4'd7: begin
        packed_y[0] = {src[1][6], src[0][6:0]};
        packed_y[1] = {src[2][5:4], src[1][5:0]};
        packed_y[2] = {src[2][6], src[3][6:0]};
        packed_y[3] = {src[6][3:0], src[2][3:0]};
        packed_y[4] = {src[5][6], src[4][6:0]};
        packed_y[5] = {src[6][5:4], src[5][5:0]};
        packed_y[6] = {src[6][6], src[7][6:0]};
      end
      default: begin
        packed_y = src;
      end
    endcase
  end

  always_comb begin
    unpacked_v = '0;
    case (k)
      4'd1: begin
        for (int i = 0; i < 8; i++) begin
          unpacked_v[i] = {7'd0, src[0][i]};
        end
      end
      4'd2: begin
        for (int i = 0; i < 8; i++) begin
          unpacked_v[i] = {6'd0, src[i/4][2*(i%4) +: 2]};
        end
      end
      4'd3: begin
        unpacked_v[0] = {5'd0, src[0][2:0]};
        unpacked_v[1] = {5'd0, src[0][5:3]};
        unpacked_v[2] = {5'd0, src[1][6], src[0][7:6]};
        unpacked_v[3] = {5'd0, src[1][2:0]};
        unpacked_v[4] = {5'd0, src[1][5:3]};
        unpacked_v[5] = {5'd0, src[1][7], src[2][7:6]};
        unpacked_v[6] = {5'd0, src[2][2:0]};
        unpacked_v[7] = {5'd0, src[2][5:3]};
      end
      4'd4: begin
        for (int g = 0; g < 4; g++) begin
          unpacked_v[2*g]   = {4'd0, src[g][3:0]};
          unpacked_v[2*g+1] = {4'd0, src[g][7:4]};
        end
      end
      4'd5: begin
        for (int g = 0; g < 4; g++) begin
          unpacked_v[2*g]   = {3'd0, src[g][4:0]};
          unpacked_v[2*g+1] = {3'd0, src[g][7:5], src[4][2*g +: 2]};
        end
      end
      4'd6: begin
        for (int g = 0; g < 2; g++) begin
          unpacked_v[4*g]   = {2'd0, src[3*g][5:0]};
          unpacked_v[4*g+1] = {2'd0, src[3*g][7:6], src[3*g+1][3:0]};
          unpacked_v[4*g+2] = {2'd0, src[3*g+2][7:6], src[3*g+1][7:4]};
          unpacked_v[4*g+3] = {2'd0, src[3*g+2][5:0]};
        end
      end
      4'd7: begin
        unpacked_v[0] = {1'b0, src[0][6:0]};
        unpacked_v[1] = {1'b0, src[0][7], src[1][5:0]};
        unpacked_v[2] = {1'b0, src[2][7], src[1][7:6], src[3][3:0]};
        unpacked_v[3] = {1'b0, src[2][6:0]};
        unpacked_v[4] = {1'b0, src[4][6:0]};
        unpacked_v[5] = {1'b0, src[4][7], src[5][5:0]};
        unpacked_v[6] = {1'b0, src[6][7], src[5][7:6], src[3][7:4]};
        unpacked_v[7] = {1'b0, src[6][6:0]};
      end
      default: begin
        unpacked_v = src;
      end
    endcase
  end

  assign dst   = (dir == DIR_UNPACK) ? unpacked_v : packed_y;
  assign count = (dir == DIR_UNPACK) ? K_MAX : k;

endmodule

`default_nettype wire

>>> rtl/kbp_out_stage.sv
// Result register of the K-bit packer: holds one result item until taken.
// Depends on kbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kbp_out_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                s1_valid,
  input  wire kbp_pkg::octet_vec_t res_data,
  input  wire kbp_pkg::kwidth_t    res_count,
  output logic                     up_ready,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output kbp_pkg::octet_vec_t      out_data,
  output kbp_pkg::kwidth_t         out_count
);
  import kbp_pkg::*;

  logic       valid_r, valid_nxt;
  octet_vec_t data_r;
  kwidth_t    count_r;
  logic       load;

  assign up_ready = !valid_r || !out_stall;
  assign load     = s1_valid && up_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r  <= res_data;
      count_r <= res_count;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_count = count_r;

endmodule

`default_nettype wire

>>> rtl/k_bit_value_packer_unit.sv
// Top level of the K-bit value packer: config registers, input register,
// pack/unpack logic and result register. Depends on kbp_pkg and the stage modules.
//
// Packs eight K-bit values into K bytes, or unpacks K bytes into eight values,
// with K and direction set through the configuration port; the user must set them
// only while the block is idle, as the block itself does not enforce it. One item
// is accepted every cycle while in_stall is low. An accepted item sits in the
// input register, passes the pack/unpack logic into the result register and leaves
// when out_stall is low. A stalled result holds the pipeline without losing items.
`timescale 1ns / 1ps
`default_nettype none

`include "k_bit_value_packer_unit_macros.svh"

module k_bit_value_packer_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire kbp_pkg::cfg_idx_t  cfg_index,
  input  wire kbp_pkg::cfg_data_t cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_byte0,
  input  wire logic [7:0]         in_byte1,
  input  wire logic [7:0]         in_byte2,
  input  wire logic [7:0]         in_byte3,
  input  wire logic [7:0]         in_byte4,
  input  wire logic [7:0]         in_byte5,
  input  wire logic [7:0]         in_byte6,
  input  wire logic [7:0]         in_byte7,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte0,
  output logic [7:0]              out_byte1,
  output logic [7:0]              out_byte2,
  output logic [7:0]              out_byte3,
  output logic [7:0]              out_byte4,
  output logic [7:0]              out_byte5,
  output logic [7:0]              out_byte6,
  output logic [7:0]              out_byte7,
  output logic [3:0]              out_byte_count
);
  import kbp_pkg::*;

  kwidth_t    value_width_r;
  logic       direction_r;
  kwidth_t    k_eff;
  octet_vec_t in_data;
  octet_vec_t s1_data;
  octet_vec_t res_data;
  octet_vec_t out_data;
  kwidth_t    res_count;
  logic       s1_valid;
  logic       down_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_width_r <= K_MAX;
      direction_r   <= DIR_PACK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VALUE_WIDTH: value_width_r <= cfg_data;
        REG_DIRECTION:   direction_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    k_eff = value_width_r;
    if (value_width_r == '0) begin
      k_eff = K_MIN;
    end else if (value_width_r > K_MAX) begin
      k_eff = K_MAX;
    end
  end

  assign in_data = {in_byte7, in_byte6, in_byte5, in_byte4,
                    in_byte3, in_byte2, in_byte1, in_byte0};

  kbp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .down_ready (down_ready),
    .s1_valid   (s1_valid),
    .s1_data    (s1_data)
  );

  kbp_xform u_xform (
    .src   (s1_data),
    .k     (k_eff),
    .dir   (direction_r),
    .dst   (res_data),
    .count (res_count)
  );

  kbp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .res_data  (res_data),
    .res_count (res_count),
    .up_ready  (down_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .out_count (out_byte_count)
  );

  assign out_byte0 = out_data[0];
  assign out_byte1 = out_data[1];
  assign out_byte2 = out_data[2];
  assign out_byte3 = out_data[3];
  assign out_byte4 = out_data[4];
  assign out_byte5 = out_data[5];
  assign out_byte6 = out_data[6];
  assign out_byte7 = out_data[7];

  `KBP_ASSERT_IMPLY(a_stall_needs_item, clk, rst_n, in_stall,
                    s1_valid && out_valid && out_stall, "input stalled without a held item")
  `KBP_ASSERT_NEXT(a_item_moves_on, clk, rst_n, s1_valid && !in_stall,
                   out_valid, "held item did not reach result register")
  `KBP_ASSERT_IMPLY(a_pack_count, clk, rst_n, out_valid && (direction_r == DIR_PACK),
                    out_byte_count == k_eff, "pack byte count differs from K")
  `KBP_ASSERT_IMPLY(a_unpack_count, clk, rst_n, out_valid && (direction_r == DIR_UNPACK),
                    out_byte_count == K_MAX, "unpack byte count is not eight")
  `KBP_ASSERT_IMPLY(a_pack_tail_zero, clk, rst_n,
                    out_valid && (direction_r == DIR_PACK) && (k_eff != K_MAX),
                    out_byte7 == '0, "unused packed byte not zero")

endmodule

`default_nettype wire
